// ----- hdl/nearest_seed_voronoi_pixel_unit_assert.svh -----
`ifndef NEAREST_SEED_VORONOI_PIXEL_UNIT_ASSERT_SVH
`define NEAREST_SEED_VORONOI_PIXEL_UNIT_ASSERT_SVH

// same-cycle implication on clk, off during reset
`define NSV_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nsv: assertion failed");

// next-cycle implication on clk, off during reset
`define NSV_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nsv: assertion failed");

`endif

// ----- hdl/nsv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package nsv_pkg;

	localparam int MAX_SEEDS_DEF  = 64;
	localparam int COORD_BITS_DEF = 12;
	localparam int SLOT_W         = 6;
	localparam int COLOR_W        = 24;
	localparam int COUNT_W        = 7;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 7;

	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DISTANCE_MODE = 1'b0,
		REG_SEED_COUNT    = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		MODE_EUCLID_SQ  = 1'b0,
		MODE_MANHATTAN  = 1'b1
	} dist_mode_t;

	typedef struct packed {
		dist_mode_t         mode;
		logic [COUNT_W-1:0] count;
	} cfg_t;

endpackage

`default_nettype wire

// ----- hdl/nsv_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_seed_voronoi_pixel_unit_assert.svh"

module nsv_cell #(
	parameter int IDX        = 0,
	parameter int COORD_BITS = nsv_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  nsv_pkg::cfg_t                cfg,
	input  logic                         in_valid,
	input  nsv_pkg::func_t               in_func,
	input  logic [nsv_pkg::SLOT_W-1:0]   in_slot,
	input  logic [COORD_BITS-1:0]        in_x,
	input  logic [COORD_BITS-1:0]        in_y,
	input  logic [nsv_pkg::COLOR_W-1:0]  in_color,
	input  logic [2*COORD_BITS:0]        in_dist,
	input  logic [nsv_pkg::SLOT_W-1:0]   in_best,
	input  logic                         in_found,
	output logic                         out_valid,
	output nsv_pkg::func_t               out_func,
	output logic [nsv_pkg::SLOT_W-1:0]   out_slot,
	output logic [COORD_BITS-1:0]        out_x,
	output logic [COORD_BITS-1:0]        out_y,
	output logic [nsv_pkg::COLOR_W-1:0]  out_color,
	output logic [2*COORD_BITS:0]        out_dist,
	output logic [nsv_pkg::SLOT_W-1:0]   out_best,
	output logic                         out_found
);
	import nsv_pkg::*;

	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int DIST_W = SQ_W + 1;

	// seed held by this slot
	logic [COORD_BITS-1:0] seed_x_q;
	logic [COORD_BITS-1:0] seed_y_q;
	logic [COLOR_W-1:0]    seed_color_q;

	logic                  v_s1, v_s2, v_s3;
	func_t                 func_s1, func_s2, func_s3;
	logic [SLOT_W-1:0]     slot_s1, slot_s2, slot_s3;
	logic [COORD_BITS-1:0] x_s1, x_s2, x_s3;
	logic [COORD_BITS-1:0] y_s1, y_s2, y_s3;
	logic [COLOR_W-1:0]    color_s1, color_s2, color_s3;
	logic [DIST_W-1:0]     dist_s1, dist_s2, dist_s3;
	logic [SLOT_W-1:0]     best_s1, best_s2, best_s3;
	logic                  found_s1, found_s2, found_s3;
	logic [COORD_BITS-1:0] dx_s1, dy_s1;
	logic [COLOR_W-1:0]    cand_s1, cand_s2;
	logic [SQ_W-1:0]       t0_s2, t1_s2;

	logic                  load_hit;
	logic [COORD_BITS-1:0] dx, dy;
	logic [SQ_W-1:0]       t0, t1;
	logic [DIST_W-1:0]     d;
	logic                  active;
	logic                  take;

	assign load_hit = adv && in_valid && (in_func == FUNC_LOAD) && (int'(in_slot) == IDX);

	always_ff @(posedge clk) begin
		if (load_hit) begin
			seed_x_q     <= in_x;
			seed_y_q     <= in_y;
			seed_color_q <= in_color;
		end
	end

	// stage 1: absolute differences
	assign dx = (in_x > seed_x_q) ? (in_x - seed_x_q) : (seed_x_q - in_x);
	assign dy = (in_y > seed_y_q) ? (in_y - seed_y_q) : (seed_y_q - in_y);

	// stage 2: squares or plain terms
	always_comb begin
		if (cfg.mode == MODE_MANHATTAN) begin
			t0 = SQ_W'(dx_s1);
			t1 = SQ_W'(dy_s1);
		end else begin
			t0 = SQ_W'(dx_s1) * SQ_W'(dx_s1);
			t1 = SQ_W'(dy_s1) * SQ_W'(dy_s1);
		end
	end

	// stage 3: sum and strict compare, lower slot wins ties
	assign d      = DIST_W'(t0_s2) + DIST_W'(t1_s2);
	assign active = int'(cfg.count) > IDX;
	assign take   = v_s2 && (func_s2 == FUNC_QUERY) && active && (!found_s2 || (d < dist_s2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1  <= in_func;
			slot_s1  <= in_slot;
			x_s1     <= in_x;
			y_s1     <= in_y;
			color_s1 <= in_color;
			dist_s1  <= in_dist;
			best_s1  <= in_best;
			found_s1 <= in_found;
			dx_s1    <= dx;
			dy_s1    <= dy;
			cand_s1  <= seed_color_q;

			func_s2  <= func_s1;
			slot_s2  <= slot_s1;
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			color_s2 <= color_s1;
			dist_s2  <= dist_s1;
			best_s2  <= best_s1;
			found_s2 <= found_s1;
			t0_s2    <= t0;
			t1_s2    <= t1;
			cand_s2  <= cand_s1;

			func_s3  <= func_s2;
			slot_s3  <= slot_s2;
			x_s3     <= x_s2;
			y_s3     <= y_s2;
			color_s3 <= take ? cand_s2 : color_s2;
			dist_s3  <= take ? d : dist_s2;
			best_s3  <= take ? SLOT_W'(IDX) : best_s2;
			found_s3 <= found_s2 | take;
		end
	end

	assign out_valid = v_s3;
	assign out_func  = func_s3;
	assign out_slot  = slot_s3;
	assign out_x     = x_s3;
	assign out_y     = y_s3;
	assign out_color = color_s3;
	assign out_dist  = dist_s3;
	assign out_best  = best_s3;
	assign out_found = found_s3;

	`NSV_ASSERT_NEXT(a_take_sets_best, adv && take, found_s3 && (best_s3 == SLOT_W'(IDX)))
	`NSV_ASSERT_NEXT(a_found_kept, adv && v_s2 && found_s2, found_s3)
	`NSV_ASSERT_NEXT(a_hold_on_stall, !adv && v_s3, v_s3 && $stable(dist_s3) && $stable(best_s3))

endmodule

`default_nettype wire

// ----- hdl/nearest_seed_voronoi_pixel_unit.sv -----
// Nearest-seed pixel colorer. One word per cycle enters on the req channel while
// req_stall is low: a load (func 0) writes a seed slot, a query (func 1) returns
// the color and slot of the nearest seed among the first seed_count slots on the
// rsp channel; loads give no response. The pipeline is a chain of MAX_SEEDS cells,
// one per slot, each three register stages deep (difference, square, compare), and
// the pipe sustains one word per cycle while the response is not stalled. Loads
// ride the same chain, so every query sees exactly the loads taken before it. A
// stalled response holds the whole chain. Write distance_mode and seed_count only
// with the pipe empty.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_seed_voronoi_pixel_unit_assert.svh"

module nearest_seed_voronoi_pixel_unit #(
	parameter int MAX_SEEDS  = nsv_pkg::MAX_SEEDS_DEF,
	parameter int COORD_BITS = nsv_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [nsv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nsv_pkg::CFG_DATA_W-1:0] cfg_data,

	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic                           func,
	input  logic [nsv_pkg::SLOT_W-1:0]     seed_slot,
	input  logic [COORD_BITS-1:0]          seed_x,
	input  logic [COORD_BITS-1:0]          seed_y,
	input  logic [nsv_pkg::COLOR_W-1:0]    seed_color,
	input  logic [COORD_BITS-1:0]          pixel_x,
	input  logic [COORD_BITS-1:0]          pixel_y,

	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [nsv_pkg::COLOR_W-1:0]    pixel_color,
	output logic [nsv_pkg::SLOT_W-1:0]     nearest_slot,
	output logic                           found
);
	import nsv_pkg::*;

	localparam int DIST_W = 2 * COORD_BITS + 1;

	cfg_t cfg_q;
	logic adv;

	logic                  ch_valid [MAX_SEEDS+1];
	func_t                 ch_func  [MAX_SEEDS+1];
	logic [SLOT_W-1:0]     ch_slot  [MAX_SEEDS+1];
	logic [COORD_BITS-1:0] ch_x     [MAX_SEEDS+1];
	logic [COORD_BITS-1:0] ch_y     [MAX_SEEDS+1];
	logic [COLOR_W-1:0]    ch_color [MAX_SEEDS+1];
	logic [DIST_W-1:0]     ch_dist  [MAX_SEEDS+1];
	logic [SLOT_W-1:0]     ch_best  [MAX_SEEDS+1];
	logic                  ch_found [MAX_SEEDS+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{mode: MODE_EUCLID_SQ, count: '0};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DISTANCE_MODE: cfg_q.mode  <= dist_mode_t'(cfg_data[0]);
				REG_SEED_COUNT:    cfg_q.count <= cfg_data[COUNT_W-1:0];
			endcase
		end
	end

	assign adv       = !(rsp_valid && rsp_stall);
	assign req_stall = !adv;

	// loads carry the seed, queries the pixel and an empty best
	assign ch_valid[0] = req_valid;
	assign ch_func[0]  = func_t'(func);
	assign ch_slot[0]  = seed_slot;
	assign ch_x[0]     = (func_t'(func) == FUNC_QUERY) ? pixel_x : seed_x;
	assign ch_y[0]     = (func_t'(func) == FUNC_QUERY) ? pixel_y : seed_y;
	assign ch_color[0] = (func_t'(func) == FUNC_QUERY) ? '0 : seed_color;
	assign ch_dist[0]  = '0;
	assign ch_best[0]  = '0;
	assign ch_found[0] = 1'b0;

	for (genvar k = 0; k < MAX_SEEDS; k++) begin : g_cell
		nsv_cell #(
			.IDX        (k),
			.COORD_BITS (COORD_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.cfg       (cfg_q),
			.in_valid  (ch_valid[k]),
			.in_func   (ch_func[k]),
			.in_slot   (ch_slot[k]),
			.in_x      (ch_x[k]),
			.in_y      (ch_y[k]),
			.in_color  (ch_color[k]),
			.in_dist   (ch_dist[k]),
			.in_best   (ch_best[k]),
			.in_found  (ch_found[k]),
			.out_valid (ch_valid[k+1]),
			.out_func  (ch_func[k+1]),
			.out_slot  (ch_slot[k+1]),
			.out_x     (ch_x[k+1]),
			.out_y     (ch_y[k+1]),
			.out_color (ch_color[k+1]),
			.out_dist  (ch_dist[k+1]),
			.out_best  (ch_best[k+1]),
			.out_found (ch_found[k+1])
		);
	end

	// loads drop off at the end of the chain
	assign rsp_valid    = ch_valid[MAX_SEEDS] && (ch_func[MAX_SEEDS] == FUNC_QUERY);
	assign pixel_color  = ch_color[MAX_SEEDS];
	assign nearest_slot = ch_best[MAX_SEEDS];
	assign found        = ch_found[MAX_SEEDS];

	`NSV_ASSERT_IMPL(a_empty_is_zero, rsp_valid && !found, (pixel_color == '0) && (nearest_slot == '0))

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import nsv_pkg::*;

	localparam int SEEDS = MAX_SEEDS_DEF;
	localparam int DRAIN = 3 * SEEDS + 16;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		func_t       op;
		logic [5:0]  slot;
		logic [11:0] sx;
		logic [11:0] sy;
		logic [23:0] scolor;
		logic [11:0] px;
		logic [11:0] py;
	} seed_word_t;

	typedef struct packed {
		logic [23:0] color;
		logic [5:0]  slot;
		logic        hit;
	} pixel_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_reg_t cfg_index = REG_DISTANCE_MODE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic req_valid = 1'b0;
	logic req_stall;
	logic func = 1'b0;
	logic [5:0] seed_slot = '0;
	logic [11:0] seed_x = '0;
	logic [11:0] seed_y = '0;
	logic [23:0] seed_color = '0;
	logic [11:0] pixel_x = '0;
	logic [11:0] pixel_y = '0;

	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [23:0] pixel_color;
	logic [5:0] nearest_slot;
	logic found;

	// predictor state
	logic [11:0] seed_col [SEEDS];
	logic [11:0] seed_row [SEEDS];
	logic [23:0] seed_rgb [SEEDS];
	dist_mode_t mode_cfg = MODE_EUCLID_SQ;
	logic [COUNT_W-1:0] count_cfg = '0;

	// stimulus-side copy of seed positions
	logic [11:0] gen_col [SEEDS];
	logic [11:0] gen_row [SEEDS];

	seed_word_t pending_words[$];
	pixel_result_t expected_pixels[$];
	seed_word_t head_word;

	logic steady = 1'b0;
	logic hold_req = 1'b0;
	logic hold_taken = 1'b0;
	int hold_left = 0;

	int cycle_count = 0;
	int mismatches = 0;
	int loads_taken = 0;
	int queries_taken = 0;
	int empty_queries = 0;
	int results_seen = 0;
	int settings_used = 0;

	nearest_seed_voronoi_pixel_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.func(func),
		.seed_slot(seed_slot),
		.seed_x(seed_x),
		.seed_y(seed_y),
		.seed_color(seed_color),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.pixel_color(pixel_color),
		.nearest_slot(nearest_slot),
		.found(found)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic pixel_result_t nearest_seed(logic [11:0] px, logic [11:0] py);
		pixel_result_t r;
		logic [11:0] dx;
		logic [11:0] dy;
		logic [34:0] d;
		logic [34:0] best_d;
		int n;
		int i;
		r = '0;
		best_d = '0;
		n = (count_cfg > SEEDS) ? SEEDS : int'(count_cfg);
		for (i = 0; i < n; i++) begin
			dx = (px > seed_col[i]) ? px - seed_col[i] : seed_col[i] - px;
			dy = (py > seed_row[i]) ? py - seed_row[i] : seed_row[i] - py;
			if (mode_cfg == MODE_MANHATTAN)
				d = 35'(dx) + 35'(dy);
			else
				d = 35'(dx) * 35'(dx) + 35'(dy) * 35'(dy);
			if (!r.hit || d < best_d) begin
				best_d = d;
				r.slot = 6'(i);
				r.color = seed_rgb[i];
				r.hit = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic take_word(seed_word_t w);
		pixel_result_t r;
		if (w.op == FUNC_LOAD) begin
			seed_col[w.slot] = w.sx;
			seed_row[w.slot] = w.sy;
			seed_rgb[w.slot] = w.scolor;
			loads_taken++;
		end else begin
			r = nearest_seed(w.px, w.py);
			expected_pixels.push_back(r);
			queries_taken++;
			if (!r.hit)
				empty_queries++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall)
				take_word(head_word);
			if (!(req_valid && req_stall)) begin
				if (pending_words.size() != 0 && (steady || $urandom_range(99) >= 26)) begin
					head_word = pending_words.pop_front();
					req_valid <= 1'b1;
					func <= head_word.op;
					seed_slot <= head_word.slot;
					seed_x <= head_word.sx;
					seed_y <= head_word.sy;
					seed_color <= head_word.scolor;
					pixel_x <= head_word.px;
					pixel_y <= head_word.py;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// receiver back-pressure, with one long hold-off on request
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= !steady && ($urandom_range(99) < 26);
		end
	end

	always @(posedge clk) begin : check_rsp
		pixel_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("cycle %0d: unexpected word color %06h slot %0d found %0b",
						cycle_count, pixel_color, nearest_slot, found);
			end else begin
				want = expected_pixels.pop_front();
				results_seen++;
				if (pixel_color !== want.color || nearest_slot !== want.slot ||
						found !== want.hit) begin
					mismatches++;
					if (mismatches <= 10)
						$display("cycle %0d: expected color %06h slot %0d found %0b, ",
							cycle_count, want.color, want.slot, want.hit,
							"got color %06h slot %0d found %0b",
							pixel_color, nearest_slot, found);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected",
				cycle_count, expected_pixels.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic queue_load(logic [5:0] slot, logic [11:0] x, logic [11:0] y,
			logic [23:0] rgb);
		seed_word_t w;
		w = '0;
		w.op = FUNC_LOAD;
		w.slot = slot;
		w.sx = x;
		w.sy = y;
		w.scolor = rgb;
		w.px = 12'($urandom);
		w.py = 12'($urandom);
		gen_col[slot] = x;
		gen_row[slot] = y;
		pending_words.push_back(w);
	endtask

	task automatic queue_query(logic [11:0] x, logic [11:0] y);
		seed_word_t w;
		w.op = FUNC_QUERY;
		w.slot = 6'($urandom);
		w.sx = 12'($urandom);
		w.sy = 12'($urandom);
		w.scolor = 24'($urandom);
		w.px = x;
		w.py = y;
		pending_words.push_back(w);
	endtask

	task automatic queue_random(int n);
		seed_word_t w;
		int s;
		int k;
		for (k = 0; k < n; k++) begin
			w.op = ($urandom_range(99) < 25) ? FUNC_LOAD : FUNC_QUERY;
			w.slot = 6'($urandom);
			w.sx = 12'($urandom);
			w.sy = 12'($urandom);
			w.scolor = 24'($urandom);
			w.px = 12'($urandom);
			w.py = 12'($urandom);
			s = $urandom_range(SEEDS - 1);
			if (w.op == FUNC_LOAD) begin
				// share a position with another seed to provoke ties
				if ($urandom_range(3) == 0) begin
					w.sx = gen_col[s];
					w.sy = gen_row[s];
				end
				gen_col[w.slot] = w.sx;
				gen_row[w.slot] = w.sy;
			end else begin
				case ($urandom_range(7))
					0, 1: begin
						w.px = gen_col[s];
						w.py = gen_row[s];
					end
					2, 3: begin
						w.px = 12'(gen_col[s] + $urandom_range(6) - 3);
						w.py = 12'(gen_row[s] + $urandom_range(6) - 3);
					end
					4: begin
						w.px = $urandom_range(1) ? 12'hFFF : 12'h000;
						w.py = $urandom_range(1) ? 12'hFFF : 12'h000;
					end
					default: ;
				endcase
			end
			pending_words.push_back(w);
		end
	endtask

	// sender pause: all words in, all results out, pipe drained
	// (checked mid-cycle, once the driver's updates have settled)
	task automatic settle();
		while (pending_words.size() != 0 || req_valid)
			@(negedge clk);
		while (expected_pixels.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_DISTANCE_MODE)
			mode_cfg = dist_mode_t'(val[0]);
		else
			count_cfg = val;
	endtask

	task automatic set_config(dist_mode_t m, logic [COUNT_W-1:0] cnt);
		logic [5:0] junk;
		junk = 6'($urandom);
		write_reg(REG_DISTANCE_MODE, {junk, m});
		write_reg(REG_SEED_COUNT, cnt);
		settings_used++;
	endtask

	task automatic queue_corner_queries();
		queue_query(12'd0, 12'd0);
		queue_query(12'hFFF, 12'hFFF);
		queue_query(12'd2048, 12'd1024);
		queue_query(12'd2048, 12'd1025);
		queue_query(12'd0, 12'hFFF);
		queue_query(12'hFFF, 12'd0);
		queue_query(12'd100, 12'd100);
	endtask

	initial begin : stimulus
		dist_mode_t modes [8];
		logic [COUNT_W-1:0] counts [8];
		int p;
		int i;
		modes = '{MODE_EUCLID_SQ, MODE_MANHATTAN, MODE_EUCLID_SQ, MODE_MANHATTAN,
			MODE_EUCLID_SQ, MODE_MANHATTAN, MODE_EUCLID_SQ, MODE_MANHATTAN};
		counts = '{7'd64, 7'd64, 7'd64, 7'd1, 7'd127, 7'd0,
			7'($urandom_range(2, 63)), 7'($urandom_range(2, 63))};
		for (i = 0; i < SEEDS; i++) begin
			seed_col[i] = '0;
			seed_row[i] = '0;
			seed_rgb[i] = '0;
			gen_col[i] = '0;
			gen_row[i] = '0;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset config searches no seeds
		queue_query(12'd0, 12'd0);
		queue_query(12'hFFF, 12'hFFF);
		settle();

		// fill the whole table; slots 10 and 20 coincide for a tie
		for (i = 0; i < SEEDS; i++)
			queue_load(6'(i), 12'($urandom), 12'($urandom), 24'($urandom));
		queue_load(6'd0, 12'd0, 12'd0, 24'h000000);
		queue_load(6'd63, 12'hFFF, 12'hFFF, 24'hFFFFFF);
		queue_load(6'd10, 12'd2048, 12'd1024, 24'h123456);
		queue_load(6'd20, 12'd2048, 12'd1024, 24'hABCDEF);
		queue_load(6'd30, 12'd0, 12'hFFF, 24'hAAAAAA);
		queue_load(6'd31, 12'hFFF, 12'd0, 24'h555555);
		settle();

		set_config(MODE_EUCLID_SQ, 7'd64);
		queue_corner_queries();
		settle();
		set_config(MODE_MANHATTAN, 7'd127);
		queue_corner_queries();
		settle();
		set_config(MODE_EUCLID_SQ, 7'd1);
		queue_query(12'hFFF, 12'hFFF);
		queue_query(12'd0, 12'd0);
		settle();

		for (p = 0; p < 8; p++) begin
			set_config(modes[p], counts[p]);
			steady <= (p == 2);
			if (p == 4) begin
				hold_req <= 1'b1;
				queue_random(260);
			end else begin
				queue_random(45);
			end
			settle();
			steady <= 1'b0;
		end

		$display("covered %0d seed loads and %0d pixel queries (%0d with no seed searched)",
			loads_taken, queries_taken, empty_queries);
		$display("over %0d register settings, %0d result words checked, %0d mismatches",
			settings_used, results_seen, mismatches);
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
